// ===== hw/rtl/acr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants of the alignment column refiner
// Field widths, action and result codes, control states and the column map
// entry and access types used across the refiner's modules.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int ACTION_W = 2;
  localparam int SEQ_W    = 6;
  localparam int RES_W    = 9;
  localparam int REFCOL_W = 11;
  localparam int NCOL_W   = 12;
  localparam int STAMP_W  = 12;

  // The column map has one entry per reference column.
  localparam int MAP_DEPTH = 1 << REFCOL_W;
  localparam int MAP_AW    = REFCOL_W;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PLACE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SEQ_W-1:0]    sequence_req;
    logic [RES_W-1:0]    residue_index;
    logic [REFCOL_W-1:0] reference_column;
    logic                last_in_column;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [NCOL_W-1:0] out_column;
    logic [SEQ_W-1:0]  sequence_out;
    logic [RES_W-1:0]  residue_out;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    out_item_t item;
  } result_t;

  typedef struct packed {
    logic [STAMP_W-1:0] tag;
    logic [NCOL_W-1:0]  id;
  } map_entry_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
    map_entry_t        data;
  } map_wr_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_TABLE,
    ST_MAP
  } ctrl_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/acr_ref_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_ref_table: reference column table
// Simple dual-port memory holding each residue's column in the second
// alignment, with a registered read port.
// ----------------------------------------------------------------------------
module acr_ref_table import acr_pkg::*; #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [REFCOL_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output      logic [REFCOL_W-1:0] rdata
);

  logic [REFCOL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acr_column_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_column_map: reference column to output column map
// Simple dual-port memory of tagged entries; an entry counts only while its
// tag matches the current epoch.
// ----------------------------------------------------------------------------
module acr_column_map import acr_pkg::*; (
  input  wire logic       clk,
  input  wire map_rd_t    rd,
  input  wire map_wr_t    wr,
  output      map_entry_t rdata
);

  map_entry_t mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_ctrl: refiner sequencer
// Steps each placement through the table read, the map read and the map
// update, keeps the epoch, the column counter and the overflow flag, and
// clears the map tags after reset and on epoch wrap.
// ----------------------------------------------------------------------------
module acr_ctrl import acr_pkg::*; #(
  parameter int MAX_SEQUENCES = 64,
  parameter int MAX_RESIDUES  = 512,
  parameter int MAX_COLUMNS   = 2048,
  parameter int TBL_AW        = 15
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire in_item_t            req_item,
  output      logic                req_ready,
  output      logic                tbl_we,
  output      logic [TBL_AW-1:0]   tbl_waddr,
  output      logic [REFCOL_W-1:0] tbl_wdata,
  output      logic                tbl_re,
  output      logic [TBL_AW-1:0]   tbl_raddr,
  input  wire logic [REFCOL_W-1:0] tbl_rdata,
  output      map_rd_t             map_rd,
  output      map_wr_t             map_wr,
  input  wire map_entry_t          map_rdata,
  input  wire logic                out_free,
  output      result_t             res,
  output      logic                sweeping
);

  localparam int SEQ_USED = (MAX_SEQUENCES < (1 << SEQ_W)) ? MAX_SEQUENCES : (1 << SEQ_W);
  localparam int RES_USED = (MAX_RESIDUES < (1 << RES_W)) ? MAX_RESIDUES : (1 << RES_W);
  localparam int SLOT_W   = SEQ_W + RES_W;
  localparam int NCNT_W   = $clog2(MAX_COLUMNS + 1);

  localparam logic [SEQ_W:0]      SEQ_LIM  = (SEQ_W + 1)'(SEQ_USED);
  localparam logic [RES_W:0]      RES_LIM  = (RES_W + 1)'(RES_USED);
  localparam logic [SLOT_W-1:0]   RES_MUL  = SLOT_W'(RES_USED);
  localparam logic [NCNT_W-1:0]   COL_CAP  = NCNT_W'(MAX_COLUMNS);
  localparam logic [NCOL_W-1:0]   CAP_OUT  = NCOL_W'(MAX_COLUMNS);
  localparam logic [MAP_AW-1:0]   SWEEP_END = MAP_AW'(MAP_DEPTH - 1);
  localparam logic [STAMP_W-1:0]  EPOCH_ONE = STAMP_W'(1);

  ctrl_state_t state, state_next;

  logic [MAP_AW-1:0]   sweep_cnt, sweep_cnt_next;
  logic [STAMP_W-1:0]  epoch, epoch_next;
  logic [NCNT_W-1:0]   ncol, ncol_next;
  logic                ovf, ovf_next;

  // Item in flight.
  logic                st_finish;
  logic                st_last;
  logic                st_in_range;
  logic [SEQ_W-1:0]    st_seq;
  logic [RES_W-1:0]    st_res;
  logic [REFCOL_W-1:0] st_refcol;

  logic                in_range;
  logic [SLOT_W-1:0]   slot;
  logic                accept;
  logic                work_item;
  logic                resolve;
  logic                hit;
  logic                room;
  logic                advancing;
  logic                wrap_now;
  logic [REFCOL_W-1:0] c2;
  logic [31:0]         ncol_ext;
  logic [NCOL_W-1:0]   ncol_out;

  assign in_range  = ({1'b0, req_item.sequence_req} < SEQ_LIM) &&
                     ({1'b0, req_item.residue_index} < RES_LIM);
  assign slot      = SLOT_W'(req_item.sequence_req) * RES_MUL +
                     SLOT_W'(req_item.residue_index);
  assign work_item = (req_item.action == ACT_PLACE) || (req_item.action == ACT_FINISH);
  assign accept    = req_valid && req_ready;
  assign resolve   = (state == ST_MAP) && out_free;
  assign hit       = (map_rdata.tag == epoch);
  assign room      = (ncol < COL_CAP);
  assign advancing = st_finish || st_last;
  assign wrap_now  = advancing && (epoch == '1);
  assign c2        = st_in_range ? tbl_rdata : '0;
  assign ncol_ext  = 32'(ncol);
  assign ncol_out  = ncol_ext[NCOL_W-1:0];
  assign sweeping  = (state == ST_SWEEP);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_cnt == SWEEP_END) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && work_item) begin
          state_next = ST_TABLE;
        end
      end
      ST_TABLE: begin
        state_next = ST_MAP;
      end
      ST_MAP: begin
        if (out_free) begin
          if (wrap_now) begin
            state_next = ST_SWEEP;
          end else if (accept && work_item) begin
            state_next = ST_TABLE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready   = 1'b0;
    map_rd.en   = 1'b0;
    map_rd.addr = c2;
    map_wr.en   = 1'b0;
    map_wr.addr = st_refcol;
    map_wr.data = '{tag: epoch, id: ncol_out};
    res.valid   = 1'b0;
    res.item    = '{kind: KIND_PLACE, out_column: map_rdata.id, sequence_out: st_seq,
                    residue_out: st_res, overflow: ovf};
    case (state)
      ST_SWEEP: begin
        map_wr.en   = 1'b1;
        map_wr.addr = sweep_cnt;
        map_wr.data = '0;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_TABLE: begin
        map_rd.en = 1'b1;
      end
      ST_MAP: begin
        req_ready = out_free && !wrap_now;
        res.valid = out_free;
        if (st_finish) begin
          res.item = '{kind: KIND_COUNT, out_column: ncol_out, sequence_out: '0,
                       residue_out: '0, overflow: ovf};
        end else if (!hit) begin
          if (room) begin
            map_wr.en              = out_free;
            res.item.out_column    = ncol_out;
          end else begin
            res.item.out_column    = CAP_OUT;
            res.item.overflow      = 1'b1;
          end
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign tbl_we    = accept && (req_item.action == ACT_LOAD) && in_range;
  assign tbl_waddr = slot[TBL_AW-1:0];
  assign tbl_wdata = req_item.reference_column;
  assign tbl_re    = accept && work_item;
  assign tbl_raddr = slot[TBL_AW-1:0];

  // Counters, epoch and overflow flag.
  always_comb begin
    sweep_cnt_next = (state == ST_SWEEP) ? sweep_cnt + 1'b1 : '0;
    epoch_next     = epoch;
    ncol_next      = ncol;
    ovf_next       = ovf;
    if (resolve) begin
      if (st_finish) begin
        ncol_next = '0;
        ovf_next  = 1'b0;
      end else if (!hit) begin
        if (room) begin
          ncol_next = ncol + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      if (advancing) begin
        epoch_next = wrap_now ? EPOCH_ONE : epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      epoch     <= EPOCH_ONE;
      ncol      <= '0;
      ovf       <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweep_cnt_next;
      epoch     <= epoch_next;
      ncol      <= ncol_next;
      ovf       <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && work_item) begin
      st_finish   <= (req_item.action == ACT_FINISH);
      st_last     <= (req_item.action == ACT_PLACE) && req_item.last_in_column;
      st_in_range <= in_range;
      st_seq      <= req_item.sequence_req;
      st_res      <= req_item.residue_index;
    end
    if (state == ST_TABLE) begin
      st_refcol <= c2;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/alignment_column_refiner_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_column_refiner_core: alignment column refiner
// Splits the columns of one alignment by the columns of a second alignment,
// numbering the refined output columns as residues stream in.
// ----------------------------------------------------------------------------
// Use: req carries one item per beat. A load beat writes a residue's column
// in the second alignment into the reference table and gives no result. A
// place beat looks that column up and returns the residue's output column on
// rsp; residues of one input column that share a reference column share an
// output column. A finish beat returns the column count and starts over.
// Action code 3 is accepted and dropped.
// Flow: a load or dropped beat leaves the sequencer ready for the next beat.
// A place or finish beat goes through two dependent memory reads (reference
// table, then column map) before its result is handed to the rsp register;
// the next place or finish beat is taken in that cycle unless the epoch wraps,
// so such beats do not overlap; the map read and write-back set this limit.
// Reset: the map tags of all 2048 entries are cleared with req_ready low.
// The same pass runs again after every 4095th column boundary or finish,
// when the map epoch wraps. The reference table is not cleared.
// Stalls: while rsp waits, one more beat is taken; its result holds in the
// map read register until rsp frees up, and req_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module alignment_column_refiner_core import acr_pkg::*; #(
  parameter int MAX_SEQUENCES = 64,
  parameter int MAX_RESIDUES  = 512,
  parameter int MAX_COLUMNS   = 2048
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output      logic     req_ready,
  input  wire in_item_t req_item,
  output      logic     rsp_valid,
  input  wire logic     rsp_ready,
  output      out_item_t rsp_item
);

  // Only residues that the field widths can name need table space.
  localparam int SEQ_USED  = (MAX_SEQUENCES < (1 << SEQ_W)) ? MAX_SEQUENCES : (1 << SEQ_W);
  localparam int RES_USED  = (MAX_RESIDUES < (1 << RES_W)) ? MAX_RESIDUES : (1 << RES_W);
  localparam int TBL_DEPTH = SEQ_USED * RES_USED;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_waddr;
  logic [REFCOL_W-1:0] tbl_wdata;
  logic                tbl_re;
  logic [TBL_AW-1:0]   tbl_raddr;
  logic [REFCOL_W-1:0] tbl_rdata;
  map_rd_t             map_rd;
  map_wr_t             map_wr;
  map_entry_t          map_rdata;
  result_t             res;
  logic                out_free;
  logic                sweeping;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !rsp_valid || rsp_ready;

  acr_ref_table #(
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW)
  ) u_ref_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  acr_column_map u_column_map (
    .clk   (clk),
    .rd    (map_rd),
    .wr    (map_wr),
    .rdata (map_rdata)
  );

  acr_ctrl #(
    .MAX_SEQUENCES (MAX_SEQUENCES),
    .MAX_RESIDUES  (MAX_RESIDUES),
    .MAX_COLUMNS   (MAX_COLUMNS),
    .TBL_AW        (TBL_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_item  (req_item),
    .req_ready (req_ready),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_re    (tbl_re),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .map_rd    (map_rd),
    .map_wr    (map_wr),
    .map_rdata (map_rdata),
    .out_free  (out_free),
    .res       (res),
    .sweeping  (sweeping)
  );

  // Result register: parts the sequencer from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= res.valid || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      rsp_item <= res.item;
    end
  end

`ifndef SYNTHESIS
  // No beat may be taken while the map tags are being cleared.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !req_ready)
    else $error("request taken during map clearing pass");

  // The sequencer only hands over a result when the result register can take it.
  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result produced while result register is occupied");

  // A clearing pass is never entered straight from idle or a table read.
  a_sweep_after_resolve: assert property (@(posedge clk) disable iff (rst)
    $rose(sweeping) |-> $past(res.valid))
    else $error("clearing pass started without a resolved beat");
`endif

endmodule
`default_nettype wire
